FILE: hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and helpers for the triangle plane slice unit.
// ----------------------------------------------------------------------------
package tps_pkg;

   // tolerance register
   localparam int TOL_WIDTH = 16;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

   // width used by the point proximity helper (covers coordinate widths up to 64)
   localparam int PT_WIDTH = 64;

   // segment kinds on the output
   localparam logic SEG_KIND_EDGE = 1'b0;
   localparam logic SEG_KIND_CUT  = 1'b1;

   // what one triangle edge contributes
   typedef enum logic [2:0] {
      EDGE_NONE,
      EDGE_COPLANAR,
      EDGE_CUT_A,
      EDGE_CUT_B,
      EDGE_CROSS
   } edge_class_type;

   // classification of one triangle, passed from front to back
   typedef struct packed {
      edge_class_type [2:0] cls;
      logic           [2:0] emit_edge;
   } tri_meta_type;

   // two points are close when dx^2 + dy^2 <= tol^2, computed exactly
   function automatic logic close_pts(
      input logic signed [PT_WIDTH-1:0] ax,
      input logic signed [PT_WIDTH-1:0] ay,
      input logic signed [PT_WIDTH-1:0] bx,
      input logic signed [PT_WIDTH-1:0] by,
      input logic        [TOL_WIDTH-1:0] tol
   );
      logic signed [PT_WIDTH-1:0] dx;
      logic signed [PT_WIDTH-1:0] dy;
      logic        [PT_WIDTH-1:0] ux;
      logic        [PT_WIDTH-1:0] uy;
      logic        [2*TOL_WIDTH-1:0] sqx;
      logic        [2*TOL_WIDTH-1:0] sqy;
      logic        [2*TOL_WIDTH-1:0] tsq;
      logic        [2*TOL_WIDTH:0]   sum;
      logic                          fits;
      dx   = ax - bx;
      dy   = ay - by;
      ux   = dx[PT_WIDTH-1] ? PT_WIDTH'(-dx) : PT_WIDTH'(dx);
      uy   = dy[PT_WIDTH-1] ? PT_WIDTH'(-dy) : PT_WIDTH'(dy);
      fits = (ux <= {{(PT_WIDTH-TOL_WIDTH){1'b0}}, tol}) &&
             (uy <= {{(PT_WIDTH-TOL_WIDTH){1'b0}}, tol});
      sqx  = ux[TOL_WIDTH-1:0] * ux[TOL_WIDTH-1:0];
      sqy  = uy[TOL_WIDTH-1:0] * uy[TOL_WIDTH-1:0];
      tsq  = tol * tol;
      sum  = {1'b0, sqx} + {1'b0, sqy};
      return fits && (sum <= {1'b0, tsq});
   endfunction

endpackage

FILE: hdl/triangle_plane_slice_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_slice_unit
// Slices one triangle per transaction with a horizontal plane and streams
// out its coplanar edges and cut segments.
// ----------------------------------------------------------------------------
// The first segment passes the queue, the back end's idle, merge and emit
// states and the output register; a crossing edge adds a multiply then a divide.
// The back end sequencer takes a new triangle only once every segment of the
// last one has gone to the output register, and after any multiply-divide.
// A two-entry queue keeps the input accepting while the back end works.
// Reset: synchronous; queue and output empty, tolerance set to 1.
module triangle_plane_slice_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // tolerance register
   input  logic                              csr_wen,
   input  logic [tps_pkg::TOL_WIDTH-1:0]     csr_wdata,
   // triangle input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, plane_height
   input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // segment output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // start_x, start_y, end_x, end_y
   output logic [((4*COORD_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   // seg_kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int CW      = COORD_WIDTH;
   localparam int META_W  = $bits(tps_pkg::tri_meta_type);
   localparam int ENTRY_W = 6*CW + 3*(CW+1) + META_W;
   localparam int RSP_W   = ((4*CW+7)/8)*8;

   logic [tps_pkg::TOL_WIDTH-1:0] tol_ff, tol_in;

   logic [2:0][CW-1:0]     f_vx, f_vy, b_vx, b_vy;
   logic [2:0][CW:0]       f_mag, b_mag;
   tps_pkg::tri_meta_type  f_meta, b_meta;
   logic [ENTRY_W-1:0]     push_data, pop_data;
   logic                   pop_valid, pop_ready;
   logic [CW-1:0]          sx, sy, ex, ey;

   // tolerance register
   assign tol_in = csr_wen ? csr_wdata : tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tps_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // front: classify the triangle
   tps_front #(.CW(CW)) u_front (
      .tri_data (req_tdata[10*CW-1:0]),
      .tol      (tol_ff),
      .vx       (f_vx),
      .vy       (f_vy),
      .mag      (f_mag),
      .meta     (f_meta)
   );

   assign push_data = {f_meta, f_mag, f_vy, f_vx};

   // queue between front and back
   tps_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {b_meta, b_mag, b_vy, b_vx} = pop_data;

   // back: crossings, merging and segment output
   tps_back #(.CW(CW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tol       (tol_ff),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_vx      (b_vx),
      .q_vy      (b_vy),
      .q_mag     (b_mag),
      .q_meta    (b_meta),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_sx    (sx),
      .rsp_sy    (sy),
      .rsp_ex    (ex),
      .rsp_ey    (ey),
      .rsp_kind  (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({ey, ex, sy, sx});

endmodule

FILE: hdl/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module tps_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   // handshake
   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wptr_in  = do_push ? ~wptr_ff : wptr_ff;
      rptr_in  = do_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// Unpacks a triangle, measures vertex heights against the plane and
// classifies each edge as coplanar, touching, crossing or unrelated.
// ----------------------------------------------------------------------------
module tps_front #(
   parameter int CW = 32
) (
   input  logic [10*CW-1:0]                  tri_data,
   input  logic [tps_pkg::TOL_WIDTH-1:0]     tol,
   output logic [2:0][CW-1:0]                vx,
   output logic [2:0][CW-1:0]                vy,
   output logic [2:0][CW:0]                  mag,
   output tps_pkg::tri_meta_type             meta
);

   logic [CW-1:0]   h;
   logic [CW:0]     d    [3];
   logic [CW:0]     nd   [3];
   logic [2:0]      on_p;
   logic [2:0]      neg;
   logic [2:0]      pos;

   assign h = tri_data[9*CW +: CW];

   // per-vertex signed distance to the plane
   for (genvar i = 0; i < 3; i++) begin : g_vtx
      logic [CW-1:0] z;
      assign vx[i]   = tri_data[(3*i)*CW +: CW];
      assign vy[i]   = tri_data[(3*i+1)*CW +: CW];
      assign z       = tri_data[(3*i+2)*CW +: CW];
      assign d[i]    = {z[CW-1], z} - {h[CW-1], h};
      assign nd[i]   = -d[i];
      assign mag[i]  = d[i][CW] ? nd[i] : d[i];
      assign on_p[i] = mag[i] < {{(CW+1-tps_pkg::TOL_WIDTH){1'b0}}, tol};
      assign neg[i]  = d[i][CW];
      assign pos[i]  = !d[i][CW] && (d[i] != '0);
   end

   // per-edge classification, edges v0-v1, v1-v2, v2-v0
   for (genvar k = 0; k < 3; k++) begin : g_edge
      localparam int J = (k + 1) % 3;
      logic close_ab;
      assign close_ab = tps_pkg::close_pts(
         {{(tps_pkg::PT_WIDTH-CW){vx[k][CW-1]}}, vx[k]},
         {{(tps_pkg::PT_WIDTH-CW){vy[k][CW-1]}}, vy[k]},
         {{(tps_pkg::PT_WIDTH-CW){vx[J][CW-1]}}, vx[J]},
         {{(tps_pkg::PT_WIDTH-CW){vy[J][CW-1]}}, vy[J]},
         tol);
      always_comb begin
         meta.emit_edge[k] = 1'b0;
         if (on_p[k] && on_p[J]) begin
            meta.cls[k]       = tps_pkg::EDGE_COPLANAR;
            meta.emit_edge[k] = !close_ab;
         end else if (on_p[k]) begin
            meta.cls[k] = tps_pkg::EDGE_CUT_A;
         end else if (on_p[J]) begin
            meta.cls[k] = tps_pkg::EDGE_CUT_B;
         end else if ((neg[k] && pos[J]) || (pos[k] && neg[J])) begin
            meta.cls[k] = tps_pkg::EDGE_CROSS;
         end else begin
            meta.cls[k] = tps_pkg::EDGE_NONE;
         end
      end
   end

endmodule

FILE: hdl/tps_interp.sv
// ----------------------------------------------------------------------------
// tps_interp
// Crossing coordinate a + sign(b-a) * round(|b-a| * num / den): shift-add
// multiply one bit a cycle, then restoring divide one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tps_interp #(
   parameter int CW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [CW-1:0] a,
   input  logic [CW-1:0] b,
   input  logic [CW-1:0] num,
   input  logic [CW-1:0] den,
   output logic          busy,
   output logic [CW-1:0] result
);

   localparam int CNT_W = (CW > 1) ? $clog2(CW) : 1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL,
      PH_DIV
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    a_ff, a_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    mag_ff, mag_in;
   logic [CW-1:0]    mulb_ff, mulb_in;
   logic [CW-1:0]    den_ff, den_in;
   logic [2*CW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    low_ff, low_in;

   logic [CW:0]      diff, ndiff;
   logic [2*CW-1:0]  acc_step;
   logic [2*CW:0]    rounded;
   logic [CW:0]      trial, trial_sub;
   logic             fits;
   logic             cnt_last;

   assign diff     = {b[CW-1], b} - {a[CW-1], a};
   assign ndiff    = -diff;
   assign cnt_last = (cnt_ff == CNT_W'(CW-1));
   assign acc_step = {acc_ff[2*CW-2:0], 1'b0} +
                     (mulb_ff[CW-1] ? {{CW{1'b0}}, mag_ff} : {(2*CW){1'b0}});
   assign rounded  = {1'b0, acc_step} + {{(CW+2){1'b0}}, den_ff[CW-1:1]};
   assign trial    = {rem_ff, low_ff[CW-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits     = (trial >= {1'b0, den_ff});

   // sequencing of multiply then divide
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      mulb_in  = mulb_ff;
      den_in   = den_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_MUL;
               cnt_in   = '0;
               a_in     = a;
               neg_in   = diff[CW];
               mag_in   = diff[CW] ? ndiff[CW-1:0] : diff[CW-1:0];
               mulb_in  = num;
               den_in   = den;
               acc_in   = '0;
            end
         end
         PH_MUL: begin
            acc_in  = acc_step;
            mulb_in = {mulb_ff[CW-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               // add half the divisor for round-half-up, then split
               rem_in   = rounded[2*CW-1:CW];
               low_in   = rounded[CW-1:0];
               cnt_in   = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in = fits ? trial_sub[CW-1:0] : trial[CW-1:0];
            low_in = {low_ff[CW-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      mulb_ff <= mulb_in;
      den_ff  <= den_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
   end

   // quotient has shifted into low_ff by the end of the divide
   assign busy   = (phase_ff != PH_IDLE);
   assign result = neg_ff ? (a_ff - low_ff) : (a_ff + low_ff);

endmodule

FILE: hdl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back
// Takes classified triangles from the queue, computes crossing points,
// merges close cut points and emits the segments through an output register.
// ----------------------------------------------------------------------------
module tps_back #(
   parameter int CW = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tps_pkg::TOL_WIDTH-1:0]     tol,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  logic [2:0][CW-1:0]                q_vx,
   input  logic [2:0][CW-1:0]                q_vy,
   input  logic [2:0][CW:0]                  q_mag,
   input  tps_pkg::tri_meta_type             q_meta,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [CW-1:0]                     rsp_sx,
   output logic [CW-1:0]                     rsp_sy,
   output logic [CW-1:0]                     rsp_ex,
   output logic [CW-1:0]                     rsp_ey,
   output logic                              rsp_kind,
   output logic                              rsp_last
);

   localparam int PW = tps_pkg::PT_WIDTH;

   // segment slots: three coplanar edges, then two cut segments
   localparam logic [2:0] SEG_E0  = 3'd0;
   localparam logic [2:0] SEG_E1  = 3'd1;
   localparam logic [2:0] SEG_E2  = 3'd2;
   localparam logic [2:0] SEG_C01 = 3'd3;
   localparam logic [2:0] SEG_C12 = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_MERGE,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [2:0][CW-1:0]       vx_ff, vx_in;
   logic [2:0][CW-1:0]       vy_ff, vy_in;
   tps_pkg::tri_meta_type    meta_ff, meta_in;
   logic [2:0][CW-1:0]       cx_ff, cx_in;
   logic [2:0][CW-1:0]       cy_ff, cy_in;
   logic [4:0]               seg_ff, seg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]            sx_ff, sx_in, sy_ff, sy_in;
   logic [CW-1:0]            ex_ff, ex_in, ey_ff, ey_in;
   logic                     kind_ff, kind_in;
   logic                     last_ff, last_in;

   logic                     pop;
   logic                     any_cross;
   logic                     start;
   logic [5:0]               busy;
   logic [2:0][CW-1:0]       ix, iy;
   logic [2:0][CW-1:0]       candx, candy;
   logic [2:0]               cand_ok;
   logic                     cl01, cl02, cl12;
   logic [2:0]               acc;
   logic [1:0]               n_cut;
   logic [2:0]               sel;
   logic [4:0]               seg_left;
   logic                     out_free;

   assign pop       = (state_ff == ST_IDLE) && q_valid;
   assign q_ready   = (state_ff == ST_IDLE);
   assign any_cross = (q_meta.cls[0] == tps_pkg::EDGE_CROSS) ||
                      (q_meta.cls[1] == tps_pkg::EDGE_CROSS) ||
                      (q_meta.cls[2] == tps_pkg::EDGE_CROSS);
   assign start     = pop && any_cross;

   // one multiply-divide unit per edge and coordinate
   for (genvar k = 0; k < 3; k++) begin : g_unit
      localparam int J = (k + 1) % 3;
      logic [CW:0] den_sum;
      assign den_sum = q_mag[k] + q_mag[J];
      tps_interp #(.CW(CW)) u_ix (
         .clock  (clock),
         .reset  (reset),
         .start  (start),
         .a      (q_vx[k]),
         .b      (q_vx[J]),
         .num    (q_mag[k][CW-1:0]),
         .den    (den_sum[CW-1:0]),
         .busy   (busy[2*k]),
         .result (ix[k])
      );
      tps_interp #(.CW(CW)) u_iy (
         .clock  (clock),
         .reset  (reset),
         .start  (start),
         .a      (q_vy[k]),
         .b      (q_vy[J]),
         .num    (q_mag[k][CW-1:0]),
         .den    (den_sum[CW-1:0]),
         .busy   (busy[2*k+1]),
         .result (iy[k])
      );

      // cut point candidate of this edge
      always_comb begin
         cand_ok[k] = 1'b1;
         case (meta_ff.cls[k])
            tps_pkg::EDGE_CUT_A: begin
               candx[k] = vx_ff[k];
               candy[k] = vy_ff[k];
            end
            tps_pkg::EDGE_CUT_B: begin
               candx[k] = vx_ff[J];
               candy[k] = vy_ff[J];
            end
            tps_pkg::EDGE_CROSS: begin
               candx[k] = ix[k];
               candy[k] = iy[k];
            end
            default: begin
               candx[k]   = vx_ff[k];
               candy[k]   = vy_ff[k];
               cand_ok[k] = 1'b0;
            end
         endcase
      end
   end

   // cut point merging
   assign cl01 = tps_pkg::close_pts(
      {{(PW-CW){candx[0][CW-1]}}, candx[0]}, {{(PW-CW){candy[0][CW-1]}}, candy[0]},
      {{(PW-CW){candx[1][CW-1]}}, candx[1]}, {{(PW-CW){candy[1][CW-1]}}, candy[1]}, tol);
   assign cl02 = tps_pkg::close_pts(
      {{(PW-CW){candx[0][CW-1]}}, candx[0]}, {{(PW-CW){candy[0][CW-1]}}, candy[0]},
      {{(PW-CW){candx[2][CW-1]}}, candx[2]}, {{(PW-CW){candy[2][CW-1]}}, candy[2]}, tol);
   assign cl12 = tps_pkg::close_pts(
      {{(PW-CW){candx[1][CW-1]}}, candx[1]}, {{(PW-CW){candy[1][CW-1]}}, candy[1]},
      {{(PW-CW){candx[2][CW-1]}}, candx[2]}, {{(PW-CW){candy[2][CW-1]}}, candy[2]}, tol);
   assign acc[0] = cand_ok[0];
   assign acc[1] = cand_ok[1] && !(acc[0] && cl01);
   assign acc[2] = cand_ok[2] && !(acc[0] && cl02) && !(acc[1] && cl12);
   assign n_cut  = {1'b0, acc[0]} + {1'b0, acc[1]} + {1'b0, acc[2]};

   // lowest pending segment goes out next
   always_comb begin
      sel = SEG_C12;
      for (int s = 4; s >= 0; s--) begin
         if (seg_ff[s]) begin
            sel = 3'(s);
         end
      end
      seg_left = seg_ff & ~(5'b00001 << sel);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // control and datapath next values
   always_comb begin
      state_in     = state_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      meta_in      = meta_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      seg_in       = seg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               vx_in    = q_vx;
               vy_in    = q_vy;
               meta_in  = q_meta;
               state_in = any_cross ? ST_CALC : ST_MERGE;
            end
         end
         ST_CALC: begin
            if (busy == 6'b0) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // compact accepted cut points in edge order
            cx_in[0] = acc[0] ? candx[0] : (acc[1] ? candx[1] : candx[2]);
            cy_in[0] = acc[0] ? candy[0] : (acc[1] ? candy[1] : candy[2]);
            cx_in[1] = (acc[0] && acc[1]) ? candx[1] : candx[2];
            cy_in[1] = (acc[0] && acc[1]) ? candy[1] : candy[2];
            cx_in[2] = candx[2];
            cy_in[2] = candy[2];
            seg_in   = {(n_cut == 2'd3), (n_cut >= 2'd2), meta_ff.emit_edge};
            state_in = ({(n_cut >= 2'd2), meta_ff.emit_edge} == 4'b0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               seg_in       = seg_left;
               last_in      = (seg_left == 5'b0);
               kind_in      = tps_pkg::SEG_KIND_CUT;
               case (sel)
                  SEG_E0: begin
                     sx_in = vx_ff[0]; sy_in = vy_ff[0];
                     ex_in = vx_ff[1]; ey_in = vy_ff[1];
                     kind_in = tps_pkg::SEG_KIND_EDGE;
                  end
                  SEG_E1: begin
                     sx_in = vx_ff[1]; sy_in = vy_ff[1];
                     ex_in = vx_ff[2]; ey_in = vy_ff[2];
                     kind_in = tps_pkg::SEG_KIND_EDGE;
                  end
                  SEG_E2: begin
                     sx_in = vx_ff[2]; sy_in = vy_ff[2];
                     ex_in = vx_ff[0]; ey_in = vy_ff[0];
                     kind_in = tps_pkg::SEG_KIND_EDGE;
                  end
                  SEG_C01: begin
                     sx_in = cx_ff[0]; sy_in = cy_ff[0];
                     ex_in = cx_ff[1]; ey_in = cy_ff[1];
                  end
                  default: begin
                     sx_in = cx_ff[1]; sy_in = cy_ff[1];
                     ex_in = cx_ff[2]; ey_in = cy_ff[2];
                  end
               endcase
               if (seg_left == 5'b0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      meta_ff <= meta_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      seg_ff  <= seg_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sx    = sx_ff;
   assign rsp_sy    = sy_ff;
   assign rsp_ex    = ex_ff;
   assign rsp_ey    = ey_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_last  = last_ff;

endmodule
